// ===== hw/rtl/i2ctq_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C transaction queue tracker package
// Shared constants, codes and payload types of the tracker.
// ----------------------------------------------------------------------------
package i2ctq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int HIST_DEPTH  = 8;
    localparam int Q_IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);
    localparam int H_IW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int H_CW = $clog2(HIST_DEPTH + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd50;

    localparam logic [2:0] OPC_ENQUEUE  = 3'd0;
    localparam logic [2:0] OPC_SERVICE  = 3'd1;
    localparam logic [2:0] OPC_COMPLETE = 3'd2;
    localparam logic [2:0] OPC_QUERY    = 3'd3;
    localparam logic [2:0] OPC_CANCEL   = 3'd4;

    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_SET_READ = 2'd2;
    localparam logic [1:0] KIND_CONT     = 2'd3;

    localparam logic [2:0] STS_UNKNOWN = 3'd0;
    localparam logic [2:0] STS_PENDING = 3'd1;
    localparam logic [2:0] STS_ACTIVE  = 3'd2;
    localparam logic [2:0] STS_SUCCESS = 3'd3;
    localparam logic [2:0] STS_FAILED  = 3'd4;

    typedef enum logic [2:0] {
        OP_ENQ, OP_SVC, OP_CMP, OP_QRY, OP_CAN, OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        FSM_IDLE, FSM_EXEC, FSM_CANCEL
    } t_fsm;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  kind;
        logic [6:0]  device_address;
        logic [7:0]  register_address;
        logic [7:0]  byte_count;
        logic [15:0] buffer_handle;
        logic [15:0] query_id;
        logic        bus_ok;
        logic [31:0] now_ms;
    } t_cmd_in;

    typedef struct packed {
        logic [15:0] accepted_id;
        logic        dispatch_valid;
        logic [15:0] dispatch_id;
        logic [1:0]  dispatch_kind;
        logic [6:0]  dispatch_address;
        logic [7:0]  dispatch_register;
        logic [7:0]  dispatch_count;
        logic [15:0] dispatch_handle;
        logic [2:0]  query_state;
    } t_result;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  kind;
        logic [6:0]  addr;
        logic [7:0]  reg_byte;
        logic [7:0]  count;
        logic [15:0] handle;
    } t_entry;

    typedef struct packed {
        t_op         op;
        logic [1:0]  kind;
        logic [6:0]  addr;
        logic [7:0]  reg_byte;
        logic [7:0]  count;
        logic [15:0] handle;
        logic [15:0] qid;
        logic        ok;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_link;

endpackage

// ===== hw/rtl/i2ctq_front.sv =====
// ----------------------------------------------------------------------------
// I2C transaction queue tracker front end
// Accepts commands, decodes the opcode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2ctq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  i2ctq_pkg::t_cmd_in i_cmd,
    input  logic              i_pop,
    output i2ctq_pkg::t_link  o_link
);
    import i2ctq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_cmd       w_dec;

    always_comb begin
        w_dec.kind     = i_cmd.kind;
        w_dec.addr     = i_cmd.device_address;
        w_dec.reg_byte = i_cmd.register_address;
        w_dec.count    = i_cmd.byte_count;
        w_dec.handle   = i_cmd.buffer_handle;
        w_dec.qid      = i_cmd.query_id;
        w_dec.ok       = i_cmd.bus_ok;
        w_dec.now      = i_cmd.now_ms;
        unique case (i_cmd.opcode)
            OPC_ENQUEUE:  w_dec.op = OP_ENQ;
            OPC_SERVICE:  w_dec.op = OP_SVC;
            OPC_COMPLETE: w_dec.op = OP_CMP;
            OPC_QUERY:    w_dec.op = OP_QRY;
            OPC_CANCEL:   w_dec.op = OP_CAN;
            default:      w_dec.op = OP_NOP;
        endcase
    end

    assign busy   = (r_cnt == 2'd2);
    assign w_push = start && !busy;
    assign o_link.avail = (r_cnt != 2'd0);
    assign o_link.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_dec;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== hw/rtl/i2ctq_back.sv =====
// ----------------------------------------------------------------------------
// I2C transaction queue tracker back end
// Executes decoded commands against the pending queue, the current
// transaction and the success and failure id histories.
// ----------------------------------------------------------------------------
module i2ctq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2ctq_pkg::t_link   i_link,
    output logic               o_pop,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output logic               o_result_valid,
    output i2ctq_pkg::t_result o_result
);
    import i2ctq_pkg::*;

    t_fsm             r_state;
    t_fsm             n_state;
    t_cmd             r_cmd;
    logic [15:0]      r_timeout;
    t_entry           r_pend [QUEUE_DEPTH];
    logic [Q_CW-1:0]  r_pcnt;
    logic [Q_CW-1:0]  r_idx;
    t_entry           r_cur;
    logic [2:0]       r_status;
    logic [31:0]      r_start;
    logic [15:0]      r_next_id;
    logic [15:0]      r_succ [HIST_DEPTH];
    logic [H_CW-1:0]  r_scnt;
    logic [15:0]      r_fail [HIST_DEPTH];
    logic [H_CW-1:0]  r_fcnt;
    logic             r_res_valid;
    t_result          r_res;

    logic             w_emit;
    logic             w_retire;
    logic             w_disp;
    logic             w_enq_ok;
    logic [15:0]      w_id;
    logic [15:0]      w_id_inc;
    logic [15:0]      w_id_next;
    t_entry           w_new;
    logic [31:0]      w_elapsed;
    logic             w_scan_more;
    logic             w_hit_pend;
    logic             w_hit_succ;
    logic             w_hit_fail;
    logic [2:0]       w_qstate;
    t_result          w_res;

    assign w_scan_more = (r_idx < r_pcnt);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FSM_IDLE:   if (i_link.avail) n_state = FSM_EXEC;
            FSM_EXEC:   n_state = (r_cmd.op == OP_CAN) ? FSM_CANCEL : FSM_IDLE;
            FSM_CANCEL: if (!w_scan_more) n_state = FSM_IDLE;
            default:    n_state = FSM_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop  = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            FSM_IDLE:   o_pop  = i_link.avail;
            FSM_EXEC:   w_emit = (r_cmd.op != OP_CAN);
            FSM_CANCEL: w_emit = !w_scan_more;
            default: begin
                o_pop  = 1'b0;
                w_emit = 1'b0;
            end
        endcase
    end

    // Service: retire a finished or timed-out transaction, then dispatch.
    always_comb begin
        w_elapsed = r_cmd.now - r_start;
        w_retire  = (r_cur.id != 16'd0) &&
                    ((r_status == STS_SUCCESS) || (r_status == STS_FAILED) ||
                     ((r_status == STS_ACTIVE) && (w_elapsed > {16'd0, r_timeout})));
        w_disp    = (r_pcnt != '0) && ((r_cur.id == 16'd0) || w_retire);
    end

    // Enqueue: ids wrap and never take the value zero.
    always_comb begin
        w_enq_ok  = (r_pcnt < Q_CW'(QUEUE_DEPTH)) &&
                    ((r_cmd.kind == KIND_SET_READ) || (r_cmd.count != 8'd0));
        w_id      = (r_next_id == 16'd0) ? 16'd1 : r_next_id;
        w_id_inc  = w_id + 16'd1;
        w_id_next = (w_id_inc == 16'd0) ? 16'd1 : w_id_inc;
        w_new.id       = w_id;
        w_new.kind     = r_cmd.kind;
        w_new.addr     = r_cmd.addr;
        w_new.reg_byte = (r_cmd.kind == KIND_CONT) ? 8'd0 : r_cmd.reg_byte;
        w_new.count    = (r_cmd.kind == KIND_SET_READ) ? 8'd0 : r_cmd.count;
        w_new.handle   = (r_cmd.kind == KIND_SET_READ) ? 16'd0 : r_cmd.handle;
    end

    // Query looks at every live slot at once, in order of precedence.
    always_comb begin
        w_hit_pend = 1'b0;
        w_hit_succ = 1'b0;
        w_hit_fail = 1'b0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if ((Q_CW'(k) < r_pcnt) && (r_pend[k].id == r_cmd.qid)) w_hit_pend = 1'b1;
        end
        for (int k = 0; k < HIST_DEPTH; k++) begin
            if ((H_CW'(k) < r_scnt) && (r_succ[k] == r_cmd.qid)) w_hit_succ = 1'b1;
            if ((H_CW'(k) < r_fcnt) && (r_fail[k] == r_cmd.qid)) w_hit_fail = 1'b1;
        end
        priority if (r_cmd.qid == 16'd0)  w_qstate = STS_UNKNOWN;
        else if (r_cur.id == r_cmd.qid)   w_qstate = r_status;
        else if (w_hit_pend)              w_qstate = STS_PENDING;
        else if (w_hit_succ)              w_qstate = STS_SUCCESS;
        else if (w_hit_fail)              w_qstate = STS_FAILED;
        else                              w_qstate = STS_UNKNOWN;
    end

    always_comb begin
        w_res = '0;
        if (r_state == FSM_EXEC) begin
            unique case (r_cmd.op)
                OP_ENQ: if (w_enq_ok) w_res.accepted_id = w_id;
                OP_SVC: if (w_disp) begin
                    w_res.dispatch_valid    = 1'b1;
                    w_res.dispatch_id       = r_pend[0].id;
                    w_res.dispatch_kind     = r_pend[0].kind;
                    w_res.dispatch_address  = r_pend[0].addr;
                    w_res.dispatch_register = r_pend[0].reg_byte;
                    w_res.dispatch_count    = r_pend[0].count;
                    w_res.dispatch_handle   = r_pend[0].handle;
                end
                OP_QRY: w_res.query_state = w_qstate;
                OP_CMP, OP_CAN, OP_NOP: w_res = '0;
                default: w_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_timeout   <= TIMEOUT_RESET;
            r_pcnt      <= '0;
            r_idx       <= '0;
            r_cur       <= '0;
            r_status    <= STS_UNKNOWN;
            r_start     <= 32'd0;
            r_next_id   <= 16'd0;
            r_scnt      <= '0;
            r_fcnt      <= '0;
            r_res_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= w_emit;
            if (w_emit) r_res <= w_res;
            if (i_cfg_we) r_timeout <= i_cfg_data;
            if (o_pop) r_cmd <= i_link.cmd;

            if (r_state == FSM_EXEC) begin
                unique case (r_cmd.op)
                    OP_ENQ: if (w_enq_ok) begin
                        r_pend[r_pcnt[Q_IW-1:0]] <= w_new;
                        r_pcnt    <= r_pcnt + 1'b1;
                        r_next_id <= w_id_next;
                    end
                    OP_SVC: begin
                        if (w_retire) begin
                            // A dispatch in the same cycle replaces the whole entry.
                            if (!w_disp) r_cur.id <= 16'd0;
                            if (r_status == STS_SUCCESS) begin
                                if (r_scnt == H_CW'(HIST_DEPTH)) begin
                                    for (int k = 0; k < HIST_DEPTH - 1; k++)
                                        r_succ[k] <= r_succ[k+1];
                                    r_succ[HIST_DEPTH-1] <= r_cur.id;
                                end else begin
                                    r_succ[r_scnt[H_IW-1:0]] <= r_cur.id;
                                    r_scnt <= r_scnt + 1'b1;
                                end
                            end else begin
                                if (r_fcnt == H_CW'(HIST_DEPTH)) begin
                                    for (int k = 0; k < HIST_DEPTH - 1; k++)
                                        r_fail[k] <= r_fail[k+1];
                                    r_fail[HIST_DEPTH-1] <= r_cur.id;
                                end else begin
                                    r_fail[r_fcnt[H_IW-1:0]] <= r_cur.id;
                                    r_fcnt <= r_fcnt + 1'b1;
                                end
                            end
                        end
                        if (w_disp) begin
                            r_cur <= r_pend[0];
                            for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                                r_pend[k] <= r_pend[k+1];
                            r_pcnt   <= r_pcnt - 1'b1;
                            r_status <= STS_ACTIVE;
                            r_start  <= r_cmd.now;
                        end
                    end
                    OP_CMP: if ((r_cur.id != 16'd0) && (r_status == STS_ACTIVE)) begin
                        r_status <= r_cmd.ok ? STS_SUCCESS : STS_FAILED;
                    end
                    OP_CAN: r_idx <= '0;
                    OP_QRY, OP_NOP: ;
                    default: ;
                endcase
            end

            // Cancel walks the queue one slot a cycle; a match closes the gap.
            if ((r_state == FSM_CANCEL) && w_scan_more) begin
                if (r_pend[r_idx[Q_IW-1:0]].addr == r_cmd.addr) begin
                    for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                        if (Q_CW'(k) >= r_idx) r_pend[k] <= r_pend[k+1];
                    r_pcnt <= r_pcnt - 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// ===== hw/rtl/i2c_transaction_queue_tracker_core.sv =====
// ----------------------------------------------------------------------------
// I2C transaction queue tracker
// Command queue and status tracker for an I2C master.
// ----------------------------------------------------------------------------
// A result strobes once the command has passed the front queue, the back end
// command register and the result register; a cancel first walks the queue.
// The back end sequencer finishes one transaction before it takes the next;
// the two-entry command queue raises busy only when it is full.
// The result valid strobe is high for a single cycle and cannot be stalled.
// Synchronous reset empties the queue and histories and sets timeout to 50.
module i2c_transaction_queue_tracker_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  i2ctq_pkg::t_cmd_in i_cmd,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output logic               o_result_valid,
    output i2ctq_pkg::t_result o_result
);
    import i2ctq_pkg::*;

    t_link w_link;
    logic  w_pop;

    i2ctq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_pop   (w_pop),
        .o_link  (w_link)
    );

    i2ctq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_link         (w_link),
        .o_pop          (w_pop),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ===== hw/rtl/i2ctq_checker.sv =====
// ----------------------------------------------------------------------------
// I2C transaction queue tracker checker
// Port-level assertions on the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module i2ctq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_valid,
    input i2ctq_pkg::t_result o_result
);
    import i2ctq_pkg::*;

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!busy && !o_result_valid))
        else $error("busy or result strobe set straight after reset");

    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_idle_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.dispatch_valid) |->
        (o_result.dispatch_id == 16'd0 && o_result.dispatch_handle == 16'd0 &&
         o_result.dispatch_count == 8'd0))
        else $error("dispatch fields set without a dispatch");

    a_dispatch_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.dispatch_valid) |->
        (o_result.dispatch_id != 16'd0 && o_result.accepted_id == 16'd0 &&
         o_result.query_state == STS_UNKNOWN))
        else $error("dispatch carries id zero or mixed result fields");

endmodule

bind i2c_transaction_queue_tracker_core i2ctq_checker u_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// I2C transaction queue tracker testbench
// Drives directed and random transactions into the tracker, predicts every
// result with a behavioural copy of the queue and histories, and compares
// each result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import i2ctq_pkg::*;

    localparam int CMD_W = $bits(t_cmd_in);

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd_in     i_cmd;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        o_result_valid;
    t_result     o_result;

    i2c_transaction_queue_tracker_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Predictor state.
    logic [15:0] mdl_timeout;
    t_entry      mdl_queue [QUEUE_DEPTH];
    int          mdl_qcnt;
    t_entry      mdl_cur;
    logic [2:0]  mdl_status;
    logic [31:0] mdl_start;
    logic [15:0] mdl_next;
    logic [15:0] mdl_ok_hist [HIST_DEPTH];
    int          mdl_ok_cnt;
    logic [15:0] mdl_bad_hist [HIST_DEPTH];
    int          mdl_bad_cnt;

    t_result     pending_results [$];
    int          errors;
    logic [15:0] ids_seen [$];

    task automatic tracker_reset();
        mdl_timeout = TIMEOUT_RESET;
        mdl_qcnt = 0;
        mdl_cur = '0;
        mdl_status = '0;
        mdl_start = '0;
        mdl_next = '0;
        mdl_ok_cnt = 0;
        mdl_bad_cnt = 0;
    endtask

    function automatic void retire_current();
        if (mdl_status == STS_SUCCESS) begin
            if (mdl_ok_cnt >= HIST_DEPTH) begin
                for (int i = 1; i < HIST_DEPTH; i++) mdl_ok_hist[i-1] = mdl_ok_hist[i];
                mdl_ok_cnt = HIST_DEPTH - 1;
            end
            mdl_ok_hist[mdl_ok_cnt] = mdl_cur.id;
            mdl_ok_cnt++;
        end else begin
            if (mdl_bad_cnt >= HIST_DEPTH) begin
                for (int i = 1; i < HIST_DEPTH; i++) mdl_bad_hist[i-1] = mdl_bad_hist[i];
                mdl_bad_cnt = HIST_DEPTH - 1;
            end
            mdl_bad_hist[mdl_bad_cnt] = mdl_cur.id;
            mdl_bad_cnt++;
        end
        mdl_cur.id = '0;
    endfunction

    function automatic t_result tracker_predict(t_cmd_in c);
        t_result r;
        t_entry  e;
        logic    found;
        int      j;
        r = '0;
        case (c.opcode)
            OPC_ENQUEUE: begin
                if (mdl_qcnt < QUEUE_DEPTH && !(c.kind != KIND_SET_READ && c.byte_count == 0))
                begin
                    if (mdl_next == 0) mdl_next = 16'd1;
                    e.id = mdl_next;
                    mdl_next = mdl_next + 16'd1;
                    if (mdl_next == 0) mdl_next = 16'd1;
                    e.kind = c.kind;
                    e.addr = c.device_address;
                    e.reg_byte = (c.kind == KIND_CONT) ? 8'd0 : c.register_address;
                    e.count = (c.kind == KIND_SET_READ) ? 8'd0 : c.byte_count;
                    e.handle = (c.kind == KIND_SET_READ) ? 16'd0 : c.buffer_handle;
                    mdl_queue[mdl_qcnt] = e;
                    mdl_qcnt++;
                    r.accepted_id = e.id;
                    ids_seen.insert(ids_seen.size(), e.id);
                end
            end
            OPC_SERVICE: begin
                if (mdl_cur.id != 0) begin
                    if (mdl_status == STS_SUCCESS || mdl_status == STS_FAILED) begin
                        retire_current();
                    end else if (mdl_status == STS_ACTIVE) begin
                        if ((c.now_ms - mdl_start) > {16'd0, mdl_timeout}) begin
                            mdl_status = STS_FAILED;
                            retire_current();
                        end
                    end
                end
                if (mdl_qcnt > 0 && mdl_cur.id == 0) begin
                    mdl_cur = mdl_queue[0];
                    for (int i = 1; i < mdl_qcnt; i++) mdl_queue[i-1] = mdl_queue[i];
                    mdl_qcnt--;
                    mdl_status = STS_ACTIVE;
                    mdl_start = c.now_ms;
                    r.dispatch_valid = 1'b1;
                    r.dispatch_id = mdl_cur.id;
                    r.dispatch_kind = mdl_cur.kind;
                    r.dispatch_address = mdl_cur.addr;
                    r.dispatch_register = mdl_cur.reg_byte;
                    r.dispatch_count = mdl_cur.count;
                    r.dispatch_handle = mdl_cur.handle;
                end
            end
            OPC_COMPLETE: begin
                if (mdl_cur.id != 0 && mdl_status == STS_ACTIVE)
                    mdl_status = c.bus_ok ? STS_SUCCESS : STS_FAILED;
            end
            OPC_QUERY: begin
                found = 1'b0;
                if (c.query_id == 0) begin
                    found = 1'b1;
                end else if (mdl_cur.id == c.query_id) begin
                    r.query_state = mdl_status;
                    found = 1'b1;
                end
                for (int i = 0; !found && i < mdl_qcnt; i++)
                    if (mdl_queue[i].id == c.query_id) begin
                        r.query_state = STS_PENDING;
                        found = 1'b1;
                    end
                for (int i = 0; !found && i < mdl_ok_cnt; i++)
                    if (mdl_ok_hist[i] == c.query_id) begin
                        r.query_state = STS_SUCCESS;
                        found = 1'b1;
                    end
                for (int i = 0; !found && i < mdl_bad_cnt; i++)
                    if (mdl_bad_hist[i] == c.query_id) begin
                        r.query_state = STS_FAILED;
                        found = 1'b1;
                    end
            end
            OPC_CANCEL: begin
                j = 0;
                for (int i = 0; i < mdl_qcnt; i++)
                    if (mdl_queue[i].addr != c.device_address) begin
                        mdl_queue[j] = mdl_queue[i];
                        j++;
                    end
                mdl_qcnt = j;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", o_result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.accepted_id !== want.accepted_id) begin
                    $error("accepted_id exp %h got %h", want.accepted_id, o_result.accepted_id);
                    errors++;
                end
                if (o_result.dispatch_valid !== want.dispatch_valid) begin
                    $error("dispatch_valid exp %h got %h", want.dispatch_valid,
                           o_result.dispatch_valid);
                    errors++;
                end
                if (o_result.dispatch_id !== want.dispatch_id) begin
                    $error("dispatch_id exp %h got %h", want.dispatch_id, o_result.dispatch_id);
                    errors++;
                end
                if (o_result.dispatch_kind !== want.dispatch_kind) begin
                    $error("dispatch_kind exp %h got %h", want.dispatch_kind,
                           o_result.dispatch_kind);
                    errors++;
                end
                if (o_result.dispatch_address !== want.dispatch_address) begin
                    $error("dispatch_address exp %h got %h", want.dispatch_address,
                           o_result.dispatch_address);
                    errors++;
                end
                if (o_result.dispatch_register !== want.dispatch_register) begin
                    $error("dispatch_register exp %h got %h", want.dispatch_register,
                           o_result.dispatch_register);
                    errors++;
                end
                if (o_result.dispatch_count !== want.dispatch_count) begin
                    $error("dispatch_count exp %h got %h", want.dispatch_count,
                           o_result.dispatch_count);
                    errors++;
                end
                if (o_result.dispatch_handle !== want.dispatch_handle) begin
                    $error("dispatch_handle exp %h got %h", want.dispatch_handle,
                           o_result.dispatch_handle);
                    errors++;
                end
                if (o_result.query_state !== want.query_state) begin
                    $error("query_state exp %h got %h", want.query_state, o_result.query_state);
                    errors++;
                end
            end
        end
    end

    logic quiet_stretch;

    // Sends one transaction; the caller is at a falling edge. Start stays high
    // after acceptance until the next idle cycle or the next transaction.
    task automatic send_txn(t_cmd_in c, logic has_fixed, t_result fixed);
        t_result p;
        while (!quiet_stretch && $urandom_range(99) < 20) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = tracker_predict(c);
        if (has_fixed && p !== fixed) begin
            $error("directed row exp %h predictor %h", fixed, p);
            errors++;
        end
        pending_results.insert(pending_results.size(), p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (QUEUE_DEPTH + 8) @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_timeout = v;
    endtask

    function automatic t_cmd_in make_cmd(logic [2:0] op, logic [1:0] k, logic [6:0] a,
                                         logic [7:0] rg, logic [7:0] n, logic [15:0] h,
                                         logic [15:0] q, logic ok, logic [31:0] t);
        t_cmd_in c;
        c.opcode = op; c.kind = k; c.device_address = a; c.register_address = rg;
        c.byte_count = n; c.buffer_handle = h; c.query_id = q; c.bus_ok = ok;
        c.now_ms = t;
        return c;
    endfunction

    typedef struct {
        t_cmd_in cmd;
        logic    fixed;
        t_result res;
    } t_row;

    t_row    rows [$];
    t_result fr;
    t_cmd_in c;
    int      sel;
    logic [31:0] clock_ms;
    logic [6:0]  addr_pool [4];

    initial begin
        errors = 0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        quiet_stretch = 1'b0;
        i_rst_n = 1'b0;
        tracker_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: fixed results only where they follow at a glance.
        fr = '0;
        rows.insert(rows.size(), '{make_cmd(OPC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_SERVICE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_COMPLETE, 0, 0, 0, 0, 0, 0, 1, 0), 1'b1, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_ENQUEUE, KIND_WRITE, 7'h7f, 8'hff, 0,
                                            16'hffff, 0, 0, 0), 1'b1, fr});
        fr.accepted_id = 16'd1;
        rows.insert(rows.size(), '{make_cmd(OPC_ENQUEUE, KIND_WRITE, 7'h7f, 8'hff, 8'hff,
                                            16'hffff, 16'hffff, 1, 32'hffffffff), 1'b1, fr});
        fr.accepted_id = 16'd2;
        rows.insert(rows.size(), '{make_cmd(OPC_ENQUEUE, KIND_SET_READ, 7'h00, 8'h12, 0,
                                            16'h1234, 0, 0, 0), 1'b1, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_ENQUEUE, KIND_CONT, 7'h15, 8'hab, 8'd1,
                                            16'h0001, 0, 0, 0), 1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_ENQUEUE, KIND_READ, 7'h2a, 8'h00, 8'd4,
                                            16'h8000, 0, 0, 0), 1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_QUERY, 0, 0, 0, 0, 0, 16'd2, 0, 0), 1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_SERVICE, 0, 0, 0, 0, 0, 0, 0, 32'd100),
                                   1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_SERVICE, 0, 0, 0, 0, 0, 0, 0, 32'd150),
                                   1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_SERVICE, 0, 0, 0, 0, 0, 0, 0, 32'd151),
                                   1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_QUERY, 0, 0, 0, 0, 0, 16'd1, 0, 0), 1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_COMPLETE, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_SERVICE, 0, 0, 0, 0, 0, 0, 0, 32'd152),
                                   1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_QUERY, 0, 0, 0, 0, 0, 16'd2, 0, 0), 1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_COMPLETE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_CANCEL, 0, 7'h2a, 0, 0, 0, 0, 0, 0),
                                   1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_SERVICE, 0, 0, 0, 0, 0, 0, 0, 32'd160),
                                   1'b0, fr});
        rows.insert(rows.size(), '{make_cmd(OPC_QUERY, 0, 0, 0, 0, 0, 16'd4, 0, 0), 1'b0, fr});
        fr = '0;
        rows.insert(rows.size(), '{make_cmd(3'd5, 3, 7'h7f, 8'hff, 8'hff, 16'hffff, 16'hffff,
                                            1, 32'hffffffff), 1'b1, fr});
        rows.insert(rows.size(), '{make_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fr});
        for (int i = 0; i < 9; i++)
            rows.insert(rows.size(), '{make_cmd(OPC_ENQUEUE, KIND_READ, 7'h11, 8'h01, 8'd2,
                                                16'd9, 0, 0, 0), 1'b0, fr});
        foreach (rows[i]) send_txn(rows[i].cmd, rows[i].fixed, rows[i].res);

        // Random phases under different timeouts, extremes included.
        clock_ms = 32'hfffff000;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_timeout(16'd0);
                1: write_timeout(16'hffff);
                2: write_timeout(16'd20);
                3: write_timeout(16'($urandom_range(1, 500)));
                4: write_timeout(16'd50);
                default: write_timeout(16'($urandom));
            endcase
            quiet_stretch = (ph == 2);
            if (ph == 4) begin
                // The sender holds back until every prediction has been met.
                drain();
            end
            for (int a = 0; a < 4; a++) addr_pool[a] = 7'($urandom);
            for (int n = 0; n < 255; n++) begin
                c = t_cmd_in'(CMD_W'({$urandom, $urandom, $urandom}));
                sel = $urandom_range(99);
                clock_ms = clock_ms + $urandom_range(0, (ph == 5) ? 70000 : 40);
                c.now_ms = ($urandom_range(19) == 0) ? 32'($urandom) : clock_ms;
                c.device_address = addr_pool[$urandom_range(3)];
                if ($urandom_range(9) == 0) c.device_address = 7'($urandom);
                if (sel < 35) begin
                    c.opcode = OPC_ENQUEUE;
                    if ($urandom_range(9) == 0) c.byte_count = 8'd0;
                end else if (sel < 60) begin
                    c.opcode = OPC_SERVICE;
                end else if (sel < 78) begin
                    c.opcode = OPC_COMPLETE;
                    c.bus_ok = ($urandom_range(3) != 0);
                end else if (sel < 92) begin
                    c.opcode = OPC_QUERY;
                    if (ids_seen.size() != 0 && $urandom_range(4) != 0)
                        c.query_id = ids_seen[$urandom_range(ids_seen.size() - 1)];
                end else if (sel < 97) begin
                    c.opcode = OPC_CANCEL;
                end else begin
                    c.opcode = 3'($urandom_range(5, 7));
                end
                send_txn(c, 1'b0, '0);
            end
            if (ids_seen.size() > 64) ids_seen.delete(0);
        end

        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
